// ----- rtl/core/ppsm_pkg.sv -----
// shared types and constants for the pulse period speed monitor
package ppsm_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_TIMER_FREQ = 2'd0;
    localparam logic [1:0] REG_THEO_SPEED = 2'd1;
    localparam logic [1:0] REG_INIT_NOM   = 2'd2;
    localparam logic [1:0] REG_STOP_THR   = 2'd3;

    // divider operand and step counter widths
    localparam int unsigned DIV_NUM_W = 56;
    localparam int unsigned DIV_DEN_W = 32;
    localparam int unsigned DIV_CNT_W = 6;

    // request from the sequencer to the shared divider
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    // answer from the divider
    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

// ----- rtl/core/ppsm_divider.sv -----
// restoring radix-2 divider, one quotient bit per cycle
module ppsm_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  ppsm_pkg::div_req_t req,
    output ppsm_pkg::div_rsp_t rsp
);
    import ppsm_pkg::*;

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W+1:0] diff;

    // one shift and subtract step per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DIV_DEN_W-1:0], quo_reg[DIV_NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        if (req.start) begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIV_DEN_W+1]) begin
                rem_next = diff[DIV_DEN_W:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- rtl/core/ppsm_multiplier.sv -----
// shift and add multiplier, one multiplier bit per cycle
module ppsm_multiplier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [55:0] prod
);
    logic [55:0] acc_reg, acc_next;
    logic [23:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [56:0] sum_w;

    // multiplier bits consumed lsb first, partial sum shifted right with its carry
    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sum_w     = {1'b0, acc_reg};
        if (start) begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (a_reg[0]) begin
                sum_w = {1'b0, acc_reg} + {1'b0, b_reg, 24'd0};
            end
            acc_next = sum_w[56:1];
            a_next   = {1'b0, a_reg[23:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd23) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/core/pulse_period_speed_monitor_unit.sv -----
// Pulse period speed monitor: pairs of 16-bit capture stamps give a period,
// frequency timer_frequency*256/period, a running average and a belt speed.
// A stamp that only opens a pair passes through the wait and output states
// to the result register. A stamp that closes a pair takes two 56-bit
// divisions on a shared bit-serial divider (one quotient bit per cycle),
// then a serial multiply and a third division for the belt speed. On the
// step that captures the nominal the multiply and third division are
// skipped. One item is worked at a time; the next item is accepted the
// cycle after the result register is loaded, and the result register lets
// it enter while the previous result waits. A result that is still waiting
// when the next one is ready stalls the block until taken.
module pulse_period_speed_monitor_unit #(
    parameter int unsigned MAX_SAMPLES = 1000
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // capture_stamp[15:0], calibration_active[16], test_over[17], zero fill
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // measurement_valid[0], pulse_frequency[32:1], mean_freq[64:33],
    // belt_stop_seen[65], belt_stop_count[81:66], conv_rate[113:82],
    // nominal_store_request[114], nominal_speed_out[146:115], zero fill
    output logic [151:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import ppsm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FREQ  = 7'b0000010,
        ST_AVG   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_SPEED = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_WAIT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] tfreq_reg, theo_reg;
    logic [31:0] init_nom_reg;
    logic [15:0] thr_reg;

    logic [15:0] first_reg;
    logic [15:0] cnt_reg;
    logic [47:0] sum_reg;
    logic        capd_reg;
    logic [31:0] cap_nom_reg;
    logic [15:0] stop_reg;
    logic [31:0] belt_reg;
    logic [31:0] avg_reg;

    logic [15:0] stamp_reg;
    logic        cal_reg, done_in_reg;
    logic [31:0] freq_reg;
    logic        seen_reg, store_reg;

    logic         ob_valid_reg;
    logic [151:0] ob_data_reg;

    div_req_t    dreq;
    div_rsp_t    drsp;
    logic        mstart;
    logic        mdone;
    logic [55:0] mprod;

    logic [15:0] period;
    logic [31:0] nom_raw, nom_eff;
    logic [47:0] sum_new;
    logic [15:0] cnt_new;
    logic [31:0] avg_new;
    logic        pair_done;

    ppsm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    ppsm_multiplier u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mstart),
        .a       (theo_reg),
        .b       (avg_new),
        .done    (mdone),
        .prod    (mprod)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ob_valid_reg;
    assign m_tdata   = ob_data_reg;

    // nominal in effect, zero used as one
    assign nom_raw = capd_reg ? cap_nom_reg : init_nom_reg;
    assign nom_eff = (nom_raw == 32'd0) ? 32'd1 : nom_raw;

    // period and running sums
    assign period  = ((stamp_reg - first_reg) == 16'd0) ? 16'd1 : (stamp_reg - first_reg);
    assign sum_new = sum_reg + {16'd0, drsp.quo[31:0]};
    assign cnt_new = cnt_reg + 16'd1;
    assign avg_new = drsp.quo[31:0];

    always_comb begin
        dreq       = '0;
        mstart     = 1'b0;
        state_next = state_reg;
        pair_done  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (first_reg == 16'd0) begin
                    state_next = ST_OUT;
                end else begin
                    dreq.start = 1'b1;
                    dreq.num   = {24'd0, tfreq_reg, 8'd0};
                    dreq.den   = {16'd0, period};
                    state_next = ST_FREQ;
                end
            end
            ST_FREQ: begin
                if (drsp.done) begin
                    dreq.start = 1'b1;
                    dreq.num   = {8'd0, sum_new};
                    dreq.den   = {16'd0, cnt_new};
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (drsp.done) begin
                    if (!capd_reg && done_in_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        mstart     = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mdone) begin
                    dreq.start = 1'b1;
                    dreq.num   = mprod;
                    dreq.den   = nom_eff;
                    state_next = ST_SPEED;
                end
            end
            ST_SPEED: begin
                if (drsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!ob_valid_reg || m_tready) begin
                    pair_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state, configuration and accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tfreq_reg    <= 24'd10000;
            theo_reg     <= 24'd256;
            init_nom_reg <= 32'd256;
            thr_reg      <= 16'd128;
            first_reg    <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            capd_reg     <= 1'b0;
            cap_nom_reg  <= '0;
            stop_reg     <= '0;
            belt_reg     <= '0;
            avg_reg      <= '0;
            ob_valid_reg <= 1'b0;
            seen_reg     <= 1'b0;
            store_reg    <= 1'b0;
            freq_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_TIMER_FREQ: tfreq_reg    <= cfg_wdata[23:0];
                    REG_THEO_SPEED: theo_reg     <= cfg_wdata[23:0];
                    REG_INIT_NOM:   init_nom_reg <= cfg_wdata;
                    REG_STOP_THR:   thr_reg      <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_WAIT) begin
                seen_reg  <= 1'b0;
                store_reg <= 1'b0;
                freq_reg  <= '0;
            end
            if (state_reg == ST_FREQ && drsp.done) begin
                freq_reg <= drsp.quo[31:0];
                sum_reg  <= sum_new;
                cnt_reg  <= cnt_new;
            end
            if (state_reg == ST_AVG && drsp.done) begin
                avg_reg <= avg_new;
                if (cnt_reg >= 16'(MAX_SAMPLES)) begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end
                if (cal_reg && avg_new < {16'd0, thr_reg}) begin
                    seen_reg <= 1'b1;
                    if (stop_reg != 16'hFFFF) begin
                        stop_reg <= stop_reg + 16'd1;
                    end
                end
                if (!capd_reg && done_in_reg) begin
                    capd_reg    <= 1'b1;
                    cap_nom_reg <= avg_new;
                    store_reg   <= 1'b1;
                end
            end
            if (state_reg == ST_SPEED && drsp.done) begin
                belt_reg <= (drsp.quo[55:32] != 24'd0) ? 32'hFFFFFFFF : drsp.quo[31:0];
            end
            // result register valid flag
            if (pair_done) begin
                ob_valid_reg <= 1'b1;
            end else if (ob_valid_reg && m_tready) begin
                ob_valid_reg <= 1'b0;
            end
            if (pair_done) begin
                if (first_reg == 16'd0) begin
                    first_reg <= stamp_reg;
                end else begin
                    first_reg <= '0;
                end
            end
        end
    end

    // input capture and result register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stamp_reg   <= s_tdata[15:0];
            cal_reg     <= s_tdata[16];
            done_in_reg <= s_tdata[17];
        end
        if (pair_done) begin
            ob_data_reg <= {5'd0, nom_eff, store_reg, belt_reg, stop_reg, seen_reg,
                            avg_reg, freq_reg, (first_reg != 16'd0)};
        end
    end

endmodule

// ----- rtl/core/ppsm_checker.sv -----
// port level checks for the speed monitor, bound to the top level
module ppsm_assertions (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // pending results carry no frequency, stop flag or store request
    a_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0 && !m_tdata[65] && !m_tdata[114])
        else $error("pending result carries data");

    // nominal in effect never zero
    a_nom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[146:115] != 32'd0)
        else $error("zero nominal shown");

    // accepted item leaves ready low next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready after accept");

endmodule

bind pulse_period_speed_monitor_unit ppsm_assertions u_ppsm_assertions (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
